// ===== rtl/core/minifloat_mul_add_unit_macros.svh =====
// Assertion macros for the minifloat multiply-add RTL.
`ifndef MINIFLOAT_MUL_ADD_UNIT_MACROS_SVH
`define MINIFLOAT_MUL_ADD_UNIT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MFMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define MFMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mfma_pkg.sv =====
// Types and constants for the minifloat multiply-add pipeline.
package mfma_pkg;

  localparam int unsigned WordW = 12;
  localparam int unsigned ExpW  = 5;
  localparam int unsigned FracW = 7;
  localparam int unsigned SigW  = FracW + 1;
  localparam int unsigned ProdW = 2 * SigW;
  localparam int unsigned XExpW = 7;

  localparam logic [ExpW-1:0]  ExpMax   = 5'd31;
  localparam logic [ExpW-1:0]  ExpMin   = 5'd0;
  localparam logic signed [XExpW-1:0] ExpBias  = 7'sd15;
  localparam logic signed [XExpW-1:0] ExpTop   = 7'sd30;
  localparam logic signed [XExpW-1:0] ExpFloor = 7'sd1;
  localparam logic [WordW-1:0] AllOnes  = 12'hFFF;

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_ADD = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVER  = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;

  typedef struct packed {
    logic             command;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
  } mfma_in_t;

  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic [1:0]       status;
  } mfma_out_t;

  // After decode: operands ready for the multiplier or adder.
  typedef struct packed {
    logic                    command;
    logic                    ovf_in;
    logic                    zero_in;
    logic signed [XExpW-1:0] exp;
    logic [SigW-1:0]         op_x;
    logic [SigW-1:0]         op_y;
  } mfma_dec_t;

  // After the arithmetic stage: raw product or sum.
  typedef struct packed {
    logic                    command;
    logic                    ovf_in;
    logic                    zero_in;
    logic signed [XExpW-1:0] exp;
    logic [ProdW-1:0]        raw;
  } mfma_ari_t;

endpackage

// ===== rtl/core/mfma_decode.sv =====
// Stage 1: split operands, check multiply inputs, align add operands.
module mfma_decode
  import mfma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  mfma_in_t  in_item,
  output logic      vld_r,
  output mfma_dec_t dec_r
);

  logic [ExpW-1:0] ea, eb, shamt, emax;
  logic [SigW-1:0] sa, sb, big, lil;
  logic            a_ge;
  mfma_dec_t       dec_nxt;

  always_comb begin
    ea    = in_item.operand_a[WordW-1:FracW];
    eb    = in_item.operand_b[WordW-1:FracW];
    sa    = {1'b1, in_item.operand_a[FracW-1:0]};
    sb    = {1'b1, in_item.operand_b[FracW-1:0]};
    a_ge  = (ea >= eb);
    big   = a_ge ? sa : sb;
    lil   = a_ge ? sb : sa;
    shamt = a_ge ? (ea - eb) : (eb - ea);
    emax  = a_ge ? ea : eb;

    dec_nxt.command = in_item.command;
    dec_nxt.ovf_in  = 1'b0;
    dec_nxt.zero_in = 1'b0;
    if (in_item.command == CMD_MUL) begin
      dec_nxt.ovf_in  = (ea == ExpMax) || (eb == ExpMax);
      dec_nxt.zero_in = (ea == ExpMin) || (eb == ExpMin);
      dec_nxt.exp     = $signed({2'b00, ea}) + $signed({2'b00, eb}) - ExpBias;
      dec_nxt.op_x    = sa;
      dec_nxt.op_y    = sb;
    end else begin
      dec_nxt.exp  = $signed({2'b00, emax});
      dec_nxt.op_x = big;
      // drop the bits shifted out; truncation of the exact sum
      dec_nxt.op_y = lil >> shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

// ===== rtl/core/mfma_arith.sv =====
// Stage 2: significand product or aligned sum.
module mfma_arith
  import mfma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  mfma_dec_t dec,
  output logic      vld_r,
  output mfma_ari_t ari_r
);

  logic [SigW:0] sum;
  mfma_ari_t     ari_nxt;

  always_comb begin
    sum             = {1'b0, dec.op_x} + {1'b0, dec.op_y};
    ari_nxt.command = dec.command;
    ari_nxt.ovf_in  = dec.ovf_in;
    ari_nxt.zero_in = dec.zero_in;
    ari_nxt.exp     = dec.exp;
    if (dec.command == CMD_MUL) begin
      ari_nxt.raw = {{(ProdW-SigW){1'b0}}, dec.op_x} * {{(ProdW-SigW){1'b0}}, dec.op_y};
    end else begin
      ari_nxt.raw = {{(ProdW-SigW-1){1'b0}}, sum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      ari_r <= ari_nxt;
    end
  end

endmodule

// ===== rtl/core/mfma_pack.sv =====
// Stage 3: normalize, range-check and pack the result beat.
module mfma_pack
  import mfma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  mfma_ari_t ari,
  output logic      vld_r,
  output mfma_out_t res_r
);

`include "minifloat_mul_add_unit_macros.svh"

  logic                    carry;
  logic [FracW-1:0]        frac;
  logic signed [XExpW-1:0] ex_n;
  mfma_out_t               res_nxt;

  always_comb begin
    if (ari.command == CMD_MUL) begin
      carry = ari.raw[ProdW-1];
      frac  = carry ? ari.raw[ProdW-2 -: FracW] : ari.raw[ProdW-3 -: FracW];
    end else begin
      carry = ari.raw[SigW];
      frac  = carry ? ari.raw[SigW-1 -: FracW] : ari.raw[FracW-1:0];
    end
    ex_n = ari.exp + $signed({{(XExpW-1){1'b0}}, carry});

    priority if (ari.ovf_in) begin
      res_nxt.result_value = AllOnes;
      res_nxt.status       = STAT_OVER;
    end else if (ari.zero_in) begin
      res_nxt.result_value = '0;
      res_nxt.status       = STAT_UNDER;
    end else if (ex_n > ExpTop) begin
      res_nxt.result_value = AllOnes;
      res_nxt.status       = STAT_OVER;
    end else if (ex_n < ExpFloor) begin
      res_nxt.result_value = '0;
      res_nxt.status       = STAT_UNDER;
    end else begin
      res_nxt.result_value = {ex_n[ExpW-1:0], frac};
      res_nxt.status       = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      res_r <= res_nxt;
    end
  end

  `MFMA_ASSERT_SAME(a_over_all_ones, clk, rst_n, vld_r && res_r.status == STAT_OVER, res_r.result_value == AllOnes)
  `MFMA_ASSERT_SAME(a_under_zero, clk, rst_n, vld_r && res_r.status == STAT_UNDER, res_r.result_value == '0)
  `MFMA_ASSERT_SAME(a_status_legal, clk, rst_n, vld_r, res_r.status == STAT_OK || res_r.status == STAT_OVER || res_r.status == STAT_UNDER)
  `MFMA_ASSERT_NEXT(a_input_flag_wins, clk, rst_n, adv && in_vld && ari.ovf_in, vld_r && res_r.status == STAT_OVER)

endmodule

// ===== rtl/core/minifloat_mul_add_unit.sv =====
// Top level of the three-stage minifloat multiply/add pipeline.
//
//   channel | direction | handshake                | payload
//   in_     | input     | in_valid / in_stall      | in_data  (mfma_in_t)
//   out_    | output    | out_valid / out_stall    | out_data (mfma_out_t)
//
// One beat in per clock while in_stall is low; each result passes through the decode, arith and pack registers.
// Stages: decode and align, multiply or add, normalize and pack.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on out_ reaches in_stall in the same cycle and fills empty slots first.
// Synchronous reset clears the stage valid bits only.
module minifloat_mul_add_unit
  import mfma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mfma_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mfma_out_t out_data
);

  logic      v1, v2;
  logic      adv1, adv2, adv3;
  mfma_dec_t dec;
  mfma_ari_t ari;

  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  mfma_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv1),
    .in_vld (in_valid),
    .in_item(in_data),
    .vld_r  (v1),
    .dec_r  (dec)
  );

  mfma_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv2),
    .in_vld(v1),
    .dec   (dec),
    .vld_r (v2),
    .ari_r (ari)
  );

  mfma_pack u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv3),
    .in_vld(v2),
    .ari   (ari),
    .vld_r (out_valid),
    .res_r (out_data)
  );

endmodule
